FILE: design/lcdnw_pkg.sv
package lcdnw_pkg;

  localparam int CountWidthDef = 16;
  localparam int RegWidth      = 16;
  localparam int RegIdxWidth   = 3;
  localparam int NumRegs       = 6;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  // register indexes
  localparam logic [RegIdxWidth-1:0] RegEnHigh    = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegEnGap     = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegByteWait  = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegPowerUp   = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegInitLong  = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegInitShort = 3'd5;

  // register reset values
  localparam logic [RegWidth-1:0] EnHighReset    = 16'd1;
  localparam logic [RegWidth-1:0] EnGapReset     = 16'd100;
  localparam logic [RegWidth-1:0] ByteWaitReset  = 16'd2000;
  localparam logic [RegWidth-1:0] PowerUpReset   = 16'd50000;
  localparam logic [RegWidth-1:0] InitLongReset  = 16'd5000;
  localparam logic [RegWidth-1:0] InitShortReset = 16'd1000;

  // init nibbles and commands
  localparam logic [3:0] NibSync       = 4'h3;
  localparam logic [3:0] NibFourBit    = 4'h2;
  localparam logic [7:0] CmdFuncSet    = 8'h28;
  localparam logic [7:0] CmdDisplayOn  = 8'h0C;
  localparam logic [7:0] CmdEntryMode  = 8'h06;
  localparam logic [7:0] CmdClear      = 8'h01;
  localparam logic [2:0] StepLastNib   = 3'd3;
  localparam logic [2:0] StepFirstCmd  = 3'd4;
  localparam logic [2:0] StepLastCmd   = 3'd7;
  localparam logic [2:0] StepShortWait = 3'd2;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_DATA = 2'd2
  } req_kind_e;

  typedef enum logic [4:0] {
    PH_POWER   = 5'b00001,
    PH_EN_HIGH = 5'b00010,
    PH_EN_GAP  = 5'b00100,
    PH_POST    = 5'b01000,
    PH_READY   = 5'b10000
  } phase_e;

  typedef struct packed {
    req_kind_e  kind;
    logic [7:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic                   we;
    logic [RegIdxWidth-1:0] idx;
    logic [RegWidth-1:0]    data;
  } cfg_wr_t;

  // packed lowest field last: lcd_rs sits in bit 0
  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic [3:0] lcd_nibble;
    logic       lcd_en;
    logic       lcd_rs;
  } lcd_out_t;

  function automatic logic [3:0] init_nibble(input logic [2:0] step);
    return (step < StepLastNib) ? NibSync : NibFourBit;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    case (idx)
      2'd0:    cmd = CmdFuncSet;
      2'd1:    cmd = CmdDisplayOn;
      2'd2:    cmd = CmdEntryMode;
      default: cmd = CmdClear;
    endcase
    return cmd;
  endfunction

endpackage

FILE: design/lcdnw_front.sv
module lcdnw_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [7:0]            s_tdata_i,
  input  logic [1:0]            s_tuser_i,
  output logic                  q_valid_o,
  output lcdnw_pkg::queue_entry_t q_entry_o,
  input  logic                  q_pop_i
);
  import lcdnw_pkg::*;

  queue_entry_t                  mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QueueCntWidth-1:0]      count_q, count_d;
  queue_entry_t                  entry;
  logic                          push;

  // classify: unused request code counts as no request
  always_comb begin
    entry.data = s_tdata_i;
    case (s_tuser_i)
      REQ_CMD:  entry.kind = REQ_CMD;
      REQ_DATA: entry.kind = REQ_DATA;
      default:  entry.kind = REQ_NONE;
    endcase
  end

  assign s_tready_o = (count_q != QueueCntWidth'(QueueDepth));
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QueuePtrWidth'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + QueuePtrWidth'(1);
    end
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + QueueCntWidth'(1);
      2'b01:   count_d = count_q - QueueCntWidth'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

FILE: design/lcdnw_back.sv
module lcdnw_back #(
  parameter int COUNT_WIDTH = lcdnw_pkg::CountWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcdnw_pkg::cfg_wr_t      cfg_i,
  input  logic                    q_valid_i,
  input  lcdnw_pkg::queue_entry_t q_entry_i,
  output logic                    q_pop_o,
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  output lcdnw_pkg::lcd_out_t     m_tdata_o
);
  import lcdnw_pkg::*;

  localparam int LenW = ((COUNT_WIDTH > RegWidth) ? COUNT_WIDTH : RegWidth) + 1;

  logic [RegWidth-1:0]    regs_q [NumRegs];
  phase_e                 phase_q, phase_d;
  logic [2:0]             step_q, step_d;
  logic [COUNT_WIDTH-1:0] wait_q, wait_d;
  logic [7:0]             byte_q, byte_d;
  logic                   rs_q, rs_d;
  logic                   low_q, low_d;
  logic [3:0]             nib_q, nib_d;
  logic                   en_q, en_d;
  logic                   out_valid_q;
  lcd_out_t               out_q, out_d;

  phase_e                 ph;
  logic [COUNT_WIDTH-1:0] wc;
  logic                   rdy, acc, done;
  logic [RegWidth-1:0]    len_sel;
  logic [LenW-1:0]        len_raw, len_eff, len_cap;
  logic [2:0]             step_inc;
  logic [7:0]             cmd_next;

  assign q_pop_o    = q_valid_i && (!out_valid_q || m_tready_i);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;
  assign step_inc   = step_q + 3'd1;
  assign cmd_next   = init_cmd(step_inc[1:0]);

  always_comb begin
    ph     = phase_q;
    wc     = wait_q;
    byte_d = byte_q;
    rs_d   = rs_q;
    low_d  = low_q;
    nib_d  = nib_q;
    en_d   = en_q;
    step_d = step_q;
    rdy    = (phase_q == PH_READY);
    acc    = rdy && (q_entry_i.kind != REQ_NONE);

    // take the request: high nibble drives from this tick on
    if (acc) begin
      byte_d = q_entry_i.data;
      rs_d   = (q_entry_i.kind == REQ_DATA);
      low_d  = 1'b0;
      nib_d  = q_entry_i.data[7:4];
      en_d   = 1'b1;
      ph     = PH_EN_HIGH;
      wc     = '0;
    end

    out_d.accepted   = acc;
    out_d.ready_res  = rdy;
    out_d.lcd_nibble = nib_d;
    out_d.lcd_en     = en_d;
    out_d.lcd_rs     = rs_d;

    case (ph)
      PH_POWER:   len_sel = regs_q[RegPowerUp];
      PH_EN_HIGH: len_sel = regs_q[RegEnHigh];
      PH_EN_GAP:  len_sel = regs_q[RegEnGap];
      default: begin
        if (step_q < StepShortWait) begin
          len_sel = regs_q[RegInitLong];
        end else if (step_q == StepShortWait) begin
          len_sel = regs_q[RegInitShort];
        end else begin
          len_sel = regs_q[RegByteWait];
        end
      end
    endcase

    // zero acts as one, narrow counters saturate
    len_cap = LenW'(1) << COUNT_WIDTH;
    len_raw = LenW'(len_sel);
    if (len_raw == '0) begin
      len_eff = LenW'(1);
    end else if (len_raw > len_cap) begin
      len_eff = len_cap;
    end else begin
      len_eff = len_raw;
    end
    done = ((LenW'(wc) + LenW'(1)) >= len_eff);

    phase_d = ph;
    wait_d  = wc;
    if (ph != PH_READY) begin
      if (!done) begin
        wait_d = wc + COUNT_WIDTH'(1);
      end else begin
        wait_d = '0;
        case (ph)
          PH_POWER: begin
            step_d  = '0;
            nib_d   = NibSync;
            en_d    = 1'b1;
            phase_d = PH_EN_HIGH;
          end
          PH_EN_HIGH: begin
            en_d    = 1'b0;
            phase_d = PH_EN_GAP;
          end
          PH_EN_GAP: begin
            if (step_q < StepFirstCmd) begin
              if (step_q == StepLastNib) begin
                step_d  = StepFirstCmd;
                byte_d  = CmdFuncSet;
                rs_d    = 1'b0;
                low_d   = 1'b0;
                nib_d   = CmdFuncSet[7:4];
                en_d    = 1'b1;
                phase_d = PH_EN_HIGH;
              end else begin
                phase_d = PH_POST;
              end
            end else if (!low_d) begin
              low_d   = 1'b1;
              nib_d   = byte_d[3:0];
              en_d    = 1'b1;
              phase_d = PH_EN_HIGH;
            end else begin
              phase_d = PH_POST;
            end
          end
          default: begin
            if (step_q < StepLastNib) begin
              step_d  = step_inc;
              nib_d   = init_nibble(step_inc);
              en_d    = 1'b1;
              phase_d = PH_EN_HIGH;
            end else if (step_q < StepLastCmd) begin
              step_d  = step_inc;
              byte_d  = cmd_next;
              rs_d    = 1'b0;
              low_d   = 1'b0;
              nib_d   = cmd_next[7:4];
              en_d    = 1'b1;
              phase_d = PH_EN_HIGH;
            end else begin
              phase_d = PH_READY;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegEnHigh]    <= EnHighReset;
      regs_q[RegEnGap]     <= EnGapReset;
      regs_q[RegByteWait]  <= ByteWaitReset;
      regs_q[RegPowerUp]   <= PowerUpReset;
      regs_q[RegInitLong]  <= InitLongReset;
      regs_q[RegInitShort] <= InitShortReset;
    end else if (cfg_i.we && (cfg_i.idx < RegIdxWidth'(NumRegs))) begin
      regs_q[cfg_i.idx] <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_POWER;
      step_q      <= '0;
      wait_q      <= '0;
      byte_q      <= '0;
      rs_q        <= 1'b0;
      low_q       <= 1'b0;
      nib_q       <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= phase_d;
        step_q  <= step_d;
        wait_q  <= wait_d;
        byte_q  <= byte_d;
        rs_q    <= rs_d;
        low_q   <= low_d;
        nib_q   <= nib_d;
        en_q    <= en_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: design/char_lcd_nibble_write_sequencer_top.sv
// An accepted tick item passes the queue, then the output register, before its result shows.
// Throughput: one tick item per cycle when not stalled, set by the single-step sequencer.
// A two-entry queue parts intake from the sequencer; an output register holds the result.
// Reset: registers return to their defaults, the sequencer starts the power-up wait,
// the queue and the output register are empty.
module char_lcd_nibble_write_sequencer_top #(
  parameter int COUNT_WIDTH = lcdnw_pkg::CountWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcdnw_pkg::RegIdxWidth-1:0]   cfg_idx_i,
  input  logic [lcdnw_pkg::RegWidth-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // [7:0] req_byte
  input  logic [1:0]                          s_axis_tuser_i,  // [1:0] req_type
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] lcd_rs, [1] lcd_en, [5:2] lcd_nibble, [6] ready_res, [7] accepted
  output logic [7:0]                          m_axis_tdata_o
);
  import lcdnw_pkg::*;

  cfg_wr_t      cfg;
  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_entry;
  lcd_out_t     out_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  lcdnw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  lcdnw_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (out_data)
  );

  assign m_axis_tdata_o = out_data;

  a_acc_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!out_data.accepted || out_data.ready_res))
    else $error("accepted reported without ready");

  a_full_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_valid)
    else $error("intake stalled with empty queue");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !q_pop)
    else $error("queue popped while result stalled");

  a_pop_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid_o)
    else $error("popped item produced no result");

endmodule
